### hw/rtl/salru_pkg.sv
package salru_pkg;

    localparam int ADDR_W   = 32;
    localparam int SET_W    = 8;
    localparam int NUM_SETS = 256;
    localparam int NUM_WAYS = 8;
    localparam int WAY_W    = 3;
    localparam int RANK_W   = 3;
    localparam int CNT_W    = 32;
    localparam int OFF_W    = 5;
    localparam int IDX_W    = 4;
    localparam int WAYS_W   = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IX_W = 2;
    localparam int SHAMT_W  = 6;
    localparam int OUT_DATA_W = 72;

    localparam logic [OFF_W-1:0]  OFF_MAX  = 5'd16;
    localparam logic [IDX_W-1:0]  IDX_MAX  = 4'd8;
    localparam logic [WAYS_W-1:0] WAYS_MAX = 4'd8;

    localparam logic [CFG_IX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_INDEX  = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_WAYS   = 2'd2;

    typedef enum logic [1:0] {
        OUTCOME_HIT      = 2'd0,
        OUTCOME_FILL     = 2'd1,
        OUTCOME_REPLACE  = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [IDX_W-1:0]  idx;
        logic [WAYS_W-1:0] ways;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic read;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [NUM_WAYS-1:0]             valid;
        logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
        logic [NUM_WAYS-1:0][ADDR_W-1:0] tag;
    } row_t;

endpackage

### hw/rtl/salru_ctrl.sv
module salru_ctrl import salru_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.read   = (state_reg == ST_READ);
        cmd.commit = (state_reg == ST_UPDATE) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (cmd.commit) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result committed over an untaken beat");

    a_load_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.read)
        else $error("accepted beat not followed by a store read");

    a_read_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read |=> (state_reg == ST_UPDATE && !s_tready))
        else $error("store read not followed by update");

endmodule

### hw/rtl/salru_dpath.sv
module salru_dpath import salru_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    input  logic [ADDR_W-1:0] address,
    output logic              hit,
    output logic [1:0]        outcome,
    output logic [WAY_W-1:0]  way_used,
    output logic [CNT_W-1:0]  access_total,
    output logic [CNT_W-1:0]  hit_total
);

    row_t mem [NUM_SETS];

    logic [NUM_SETS-1:0] row_init_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [SET_W-1:0]    set_reg;
    logic [ADDR_W-1:0]   tag_reg;
    row_t                rd_row_reg;
    logic                row_ok_reg;
    logic [CNT_W-1:0]    acc_cnt_reg;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic [CNT_W-1:0]    acc_cnt_next;
    logic [CNT_W-1:0]    hit_cnt_next;

    logic                hit_reg;
    outcome_t            outcome_reg;
    logic [WAY_W-1:0]    way_reg;

    logic [ADDR_W-1:0]   shifted;
    logic [SET_W:0]      set_mask;
    logic [SET_W-1:0]    set_next;
    logic [SHAMT_W-1:0]  tag_shamt;
    logic [ADDR_W-1:0]   tag_next;

    logic [NUM_WAYS-1:0]             cur_valid;
    logic [NUM_WAYS-1:0][RANK_W-1:0] cur_rank;
    logic [NUM_WAYS-1:0]             in_use;
    logic                            found_hit;
    logic                            found_inv;
    logic [WAY_W-1:0]                hit_way;
    logic [WAY_W-1:0]                inv_way;
    logic [WAY_W-1:0]                lru_way;
    logic [RANK_W-1:0]               best;
    logic [WAY_W-1:0]                sel_way;
    outcome_t                        sel_outcome;
    logic [RANK_W-1:0]               old_rank;
    row_t                            wr_row;

    // set and tag split
    always_comb begin
        shifted   = addr_reg >> cfg.off;
        set_mask  = (SET_W+1)'((SET_W+1)'(1) << cfg.idx) - (SET_W+1)'(1);
        set_next  = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shamt = SHAMT_W'(cfg.off) + SHAMT_W'(cfg.idx);
        tag_next  = addr_reg >> tag_shamt;
    end

    // way search over the row just read
    always_comb begin
        cur_valid = row_ok_reg ? rd_row_reg.valid : '0;
        found_hit = 1'b0;
        found_inv = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        lru_way   = '0;
        best      = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            in_use[w]   = WAYS_W'(w) < cfg.ways;
            cur_rank[w] = cur_valid[w] ? rd_row_reg.rank[w] : '0;
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (in_use[w] && cur_valid[w] && rd_row_reg.tag[w] == tag_reg) begin
                found_hit = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (in_use[w] && !cur_valid[w]) begin
                found_inv = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (in_use[w] && cur_rank[w] >= best) begin
                best    = cur_rank[w];
                lru_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        priority if (found_hit) begin
            sel_way     = hit_way;
            sel_outcome = OUTCOME_HIT;
        end else if (found_inv) begin
            sel_way     = inv_way;
            sel_outcome = OUTCOME_FILL;
        end else begin
            sel_way     = lru_way;
            sel_outcome = OUTCOME_REPLACE;
        end
        old_rank     = cur_rank[sel_way];
        wr_row.tag   = rd_row_reg.tag;
        wr_row.valid = cur_valid;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if (WAY_W'(k) == sel_way) begin
                wr_row.rank[k] = '0;
            end else if (cur_valid[k] &&
                         (sel_outcome == OUTCOME_FILL || cur_rank[k] < old_rank)) begin
                wr_row.rank[k] = cur_rank[k] + RANK_W'(1);
            end else begin
                wr_row.rank[k] = cur_rank[k];
            end
        end
        if (sel_outcome != OUTCOME_HIT) wr_row.tag[sel_way] = tag_reg;
        if (sel_outcome == OUTCOME_FILL) wr_row.valid[sel_way] = 1'b1;
        acc_cnt_next = (acc_cnt_reg == '1) ? acc_cnt_reg : acc_cnt_reg + CNT_W'(1);
        hit_cnt_next = (found_hit && hit_cnt_reg != '1) ? hit_cnt_reg + CNT_W'(1)
                                                         : hit_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) rd_row_reg <= mem[set_next];
        if (cmd.commit) mem[set_reg] <= wr_row;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) addr_reg <= address;
        if (cmd.read) begin
            set_reg    <= set_next;
            tag_reg    <= tag_next;
            row_ok_reg <= row_init_reg[set_next];
        end
        if (cmd.commit) begin
            hit_reg     <= found_hit;
            outcome_reg <= sel_outcome;
            way_reg     <= sel_way;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_init_reg <= '0;
            acc_cnt_reg  <= '0;
            hit_cnt_reg  <= '0;
        end else if (cmd.commit) begin
            row_init_reg[set_reg] <= 1'b1;
            acc_cnt_reg           <= acc_cnt_next;
            hit_cnt_reg           <= hit_cnt_next;
        end
    end

    assign hit          = hit_reg;
    assign outcome      = outcome_reg;
    assign way_used     = way_reg;
    assign access_total = acc_cnt_reg;
    assign hit_total    = hit_cnt_reg;

endmodule

### hw/rtl/set_assoc_cache_lru_lookup.sv
// Set-associative cache tag lookup with true LRU replacement (no data store).
// Input channel s_*: one 32-bit byte address per beat. Result channel m_*:
// one beat per address with hit, outcome (hit / fill / replace), the way
// used, and saturating access and hit counts including this access.
// Configuration: cfg_we, cfg_index, cfg_data write offset bit count (0),
// index bit count (1) and ways in use (2); write only while idle.
// Each address passes through capture, tag store row read, then compare and
// row write-back. The tag store is one 256-row memory with one read and one
// write per address; a new address is taken only after that row write-back.
// m_tvalid is registered and rises once the update step commits its result.
// The result sits in an output register; a new address is taken while it
// waits. If the receiver stalls, the next lookup holds in its update step
// until the waiting beat is taken.
// Reset clears all valid bits at once through per-set flags, clears both
// counters and restores the register defaults; no clearing pass is needed.
module set_assoc_cache_lru_lookup import salru_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] address
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] hit, [2:1] outcome, [5:3] way_used, [37:6] access_total,
    // [69:38] hit_total, [71:70] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [OFF_W-1:0]  off_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WAYS_W-1:0] ways_reg;
    cfg_t              cfg;
    cmd_t              cmd;

    logic              hit;
    logic [1:0]        outcome;
    logic [WAY_W-1:0]  way_used;
    logic [CNT_W-1:0]  access_total;
    logic [CNT_W-1:0]  hit_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= OFF_W'(4);
            idx_reg  <= IDX_W'(4);
            ways_reg <= WAYS_W'(2);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OFFSET: off_reg  <= cfg_data[OFF_W-1:0];
                REG_INDEX:  idx_reg  <= cfg_data[IDX_W-1:0];
                REG_WAYS:   ways_reg <= cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.off  = (off_reg > OFF_MAX) ? OFF_MAX : off_reg;
        cfg.idx  = (idx_reg > IDX_MAX) ? IDX_MAX : idx_reg;
        if (ways_reg == '0) begin
            cfg.ways = WAYS_W'(1);
        end else if (ways_reg > WAYS_MAX) begin
            cfg.ways = WAYS_MAX;
        end else begin
            cfg.ways = ways_reg;
        end
    end

    salru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    salru_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .address      (s_tdata),
        .hit          (hit),
        .outcome      (outcome),
        .way_used     (way_used),
        .access_total (access_total),
        .hit_total    (hit_total)
    );

    assign m_tdata = {2'b00, hit_total, access_total, way_used, outcome, hit};

endmodule
